// File: src/sbqc_pkg.sv
// shared types and constants for the bracket and quote balance checker
// used by every module of the block but sbqc_ram; depends on nothing
package sbqc_pkg;

    // field widths
    localparam int LINE_W  = 24;
    localparam int DEPTH_W = 8;
    localparam int CODE_W  = 4;
    localparam int BYTE_W  = 8;

    // limits
    localparam logic [LINE_W-1:0]  LINE_MAX  = 24'hFFFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;

    // default depth of the open brace line stack
    localparam int STACK_DEPTH_DEF = 16;

    // queue between front and back
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_PTR_W = 2;
    localparam int OPQ_CNT_W = 3;

    // characters of interest
    localparam logic [BYTE_W-1:0] CH_ROUND_OPEN   = 8'h28;
    localparam logic [BYTE_W-1:0] CH_ROUND_CLOSE  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_BRACE_OPEN   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_BRACE_CLOSE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_SEMICOLON    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_NEWLINE      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SQUOTE       = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE       = 8'h22;

    // classified operations passed from front to back
    typedef enum logic [3:0] {
        OP_NONE         = 4'd0,
        OP_ROUND_OPEN   = 4'd1,
        OP_ROUND_CLOSE  = 4'd2,
        OP_NEWLINE      = 4'd3,
        OP_BRACE_OPEN   = 4'd4,
        OP_BRACE_CLOSE  = 4'd5,
        OP_SQUARE_OPEN  = 4'd6,
        OP_SQUARE_CLOSE = 4'd7,
        OP_SEMICOLON    = 4'd8,
        OP_SQUOTE       = 4'd9,
        OP_DQUOTE       = 4'd10,
        OP_END          = 4'd11
    } op_t;

    // event codes of a result
    typedef enum logic [CODE_W-1:0] {
        EV_STRAY_ROUND    = 4'd0,
        EV_ROUND_AT_NL    = 4'd1,
        EV_SQUOTE_AT_NL   = 4'd2,
        EV_DQUOTE_AT_NL   = 4'd3,
        EV_STRAY_BRACE    = 4'd4,
        EV_STRAY_SQUARE   = 4'd5,
        EV_SQUARE_AT_SEMI = 4'd6,
        EV_UNCLOSED_BRACE = 4'd7,
        EV_DONE_OK        = 4'd8,
        EV_DONE_ERR       = 4'd9
    } event_code_t;

    // one result item
    typedef struct packed {
        event_code_t       code;
        logic [LINE_W-1:0] line;
        logic              unrec;
        logic              last;
    } result_t;

endpackage

// File: src/sbqc_ram.sv
// generic single write port, single read port memory with registered read
// depends on nothing
module sbqc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sbqc_front.sv
// front end: accepts input items and classifies each into an operation
// depends on sbqc_pkg
module sbqc_front (
    input  logic                        push,
    input  logic                        full,
    input  logic                        func,
    input  logic [sbqc_pkg::BYTE_W-1:0] text_byte,
    output logic                        enq,
    output sbqc_pkg::op_t               op
);

    logic accept;

    // input transfer
    assign accept = push && !full;

    // byte classification
    always_comb
    begin
        op = sbqc_pkg::OP_NONE;
        if (func)
        begin
            op = sbqc_pkg::OP_END;
        end
        else
        begin
            unique case (text_byte)
                sbqc_pkg::CH_ROUND_OPEN:   op = sbqc_pkg::OP_ROUND_OPEN;
                sbqc_pkg::CH_ROUND_CLOSE:  op = sbqc_pkg::OP_ROUND_CLOSE;
                sbqc_pkg::CH_NEWLINE:      op = sbqc_pkg::OP_NEWLINE;
                sbqc_pkg::CH_BRACE_OPEN:   op = sbqc_pkg::OP_BRACE_OPEN;
                sbqc_pkg::CH_BRACE_CLOSE:  op = sbqc_pkg::OP_BRACE_CLOSE;
                sbqc_pkg::CH_SQUARE_OPEN:  op = sbqc_pkg::OP_SQUARE_OPEN;
                sbqc_pkg::CH_SQUARE_CLOSE: op = sbqc_pkg::OP_SQUARE_CLOSE;
                sbqc_pkg::CH_SEMICOLON:    op = sbqc_pkg::OP_SEMICOLON;
                sbqc_pkg::CH_SQUOTE:       op = sbqc_pkg::OP_SQUOTE;
                sbqc_pkg::CH_DQUOTE:       op = sbqc_pkg::OP_DQUOTE;
                default:                   op = sbqc_pkg::OP_NONE;
            endcase
        end
    end

    // bytes without meaning are dropped here
    assign enq = accept && (op != sbqc_pkg::OP_NONE);

endmodule

// File: src/sbqc_op_queue.sv
// short operation queue between the front and back ends
// depends on sbqc_pkg
module sbqc_op_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enq,
    input  sbqc_pkg::op_t enq_op,
    output logic          full,
    input  logic          deq,
    output logic          valid,
    output sbqc_pkg::op_t head_op
);

    sbqc_pkg::op_t                    entry_reg [sbqc_pkg::OPQ_DEPTH];
    logic [sbqc_pkg::OPQ_PTR_W-1:0]   wr_ptr_reg;
    logic [sbqc_pkg::OPQ_PTR_W-1:0]   rd_ptr_reg;
    logic [sbqc_pkg::OPQ_CNT_W-1:0]   count_reg;
    logic [sbqc_pkg::OPQ_CNT_W-1:0]   count_next;
    logic                             do_deq;

    assign full    = (count_reg == sbqc_pkg::OPQ_CNT_W'(sbqc_pkg::OPQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];
    assign do_deq  = deq && valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (enq && !do_deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && do_deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_op;
        end
    end

endmodule

// File: src/sbqc_back.sv
// back end: executes operations, keeps balance state and the brace line
// stack, and holds the result register; depends on sbqc_pkg and sbqc_ram
module sbqc_back #(
    parameter int STACK_DEPTH = sbqc_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  sbqc_pkg::op_t     op,
    output logic              op_pop,
    output logic              res_valid,
    output sbqc_pkg::result_t res,
    input  logic              res_take
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RW = sbqc_pkg::DEPTH_W + 1;
    localparam logic [RW-1:0] SD = RW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_RUN   = 4'b0001,
        S_READ  = 4'b0010,
        S_EMIT  = 4'b0100,
        S_FINAL = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic                                round_reg, round_next;
    logic                                square_reg, square_next;
    logic                                squote_reg, squote_next;
    logic                                dquote_reg, dquote_next;
    logic                                err_reg, err_next;
    logic [sbqc_pkg::DEPTH_W-1:0]        depth_reg, depth_next;
    logic [sbqc_pkg::LINE_W-1:0]         line_reg, line_next;
    logic [AW-1:0]                       idx_reg, idx_next;
    logic                                out_valid_reg;
    sbqc_pkg::result_t                   out_reg;

    logic                                out_free;
    logic                                emit;
    sbqc_pkg::result_t                   emit_res;
    logic                                ram_we;
    logic                                ram_re;
    logic [sbqc_pkg::LINE_W-1:0]         ram_rdata;
    logic [RW-1:0]                       depth_ext;
    logic [RW-1:0]                       recorded;
    logic                                below_stack;
    logic [sbqc_pkg::LINE_W-1:0]         line_inc;
    sbqc_pkg::event_code_t               done_code;

    // result register frees when empty or taken
    assign out_free    = !out_valid_reg || res_take;
    assign depth_ext   = {1'b0, depth_reg};
    assign below_stack = (depth_ext < SD);
    assign recorded    = below_stack ? depth_ext : SD;
    assign line_inc    = (line_reg != sbqc_pkg::LINE_MAX) ? line_reg + 1'b1 : line_reg;
    assign done_code   = err_reg ? sbqc_pkg::EV_DONE_ERR : sbqc_pkg::EV_DONE_OK;

    // brace line stack
    sbqc_ram #(
        .WIDTH (sbqc_pkg::LINE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (depth_reg[AW-1:0]),
        .wdata (line_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // operation execution and flush sequencing
    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        square_next = square_reg;
        squote_next = squote_reg;
        dquote_next = dquote_reg;
        err_next    = err_reg;
        depth_next  = depth_reg;
        line_next   = line_reg;
        idx_next    = idx_reg;
        op_pop      = 1'b0;
        emit        = 1'b0;
        emit_res    = '{code: sbqc_pkg::EV_DONE_OK, line: line_reg, unrec: 1'b0, last: 1'b1};
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (state_reg)
            S_RUN:
            begin
                if (op_valid && out_free)
                begin
                    op_pop = 1'b1;
                    case (op)
                        sbqc_pkg::OP_ROUND_OPEN:
                        begin
                            round_next = 1'b1;
                        end
                        sbqc_pkg::OP_ROUND_CLOSE:
                        begin
                            if (round_reg)
                            begin
                                round_next = 1'b0;
                            end
                            else
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_STRAY_ROUND;
                                err_next      = 1'b1;
                            end
                        end
                        sbqc_pkg::OP_NEWLINE:
                        begin
                            // one event per cycle if out_free; op stays until flags clear
                            if (round_reg)
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_ROUND_AT_NL;
                                emit_res.last = !(squote_reg || dquote_reg);
                                round_next    = 1'b0;
                                err_next      = 1'b1;
                            end
                            else if (squote_reg)
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_SQUOTE_AT_NL;
                                emit_res.last = !dquote_reg;
                                squote_next   = 1'b0;
                                err_next      = 1'b1;
                            end
                            else if (dquote_reg)
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_DQUOTE_AT_NL;
                                dquote_next   = 1'b0;
                                err_next      = 1'b1;
                            end
                            if (emit && !emit_res.last)
                            begin
                                op_pop = 1'b0;
                            end
                            else
                            begin
                                line_next = line_inc;
                            end
                        end
                        sbqc_pkg::OP_BRACE_OPEN:
                        begin
                            if (depth_reg != sbqc_pkg::DEPTH_MAX)
                            begin
                                ram_we     = below_stack;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        sbqc_pkg::OP_BRACE_CLOSE:
                        begin
                            if (depth_reg != '0)
                            begin
                                depth_next = depth_reg - 1'b1;
                            end
                            else
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_STRAY_BRACE;
                                err_next      = 1'b1;
                            end
                        end
                        sbqc_pkg::OP_SQUARE_OPEN:
                        begin
                            square_next = 1'b1;
                        end
                        sbqc_pkg::OP_SQUARE_CLOSE:
                        begin
                            if (square_reg)
                            begin
                                square_next = 1'b0;
                            end
                            else
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_STRAY_SQUARE;
                                err_next      = 1'b1;
                            end
                        end
                        sbqc_pkg::OP_SEMICOLON:
                        begin
                            if (square_reg)
                            begin
                                emit          = 1'b1;
                                emit_res.code = sbqc_pkg::EV_SQUARE_AT_SEMI;
                                square_next   = 1'b0;
                                err_next      = 1'b1;
                            end
                        end
                        sbqc_pkg::OP_SQUOTE:
                        begin
                            squote_next = !squote_reg;
                        end
                        sbqc_pkg::OP_DQUOTE:
                        begin
                            dquote_next = !dquote_reg;
                        end
                        sbqc_pkg::OP_END:
                        begin
                            if (depth_reg == '0)
                            begin
                                // nothing recorded: final status at once
                                emit          = 1'b1;
                                emit_res.code = done_code;
                                round_next    = 1'b0;
                                square_next   = 1'b0;
                                squote_next   = 1'b0;
                                dquote_next   = 1'b0;
                                err_next      = 1'b0;
                                line_next     = sbqc_pkg::LINE_W'(1);
                            end
                            else
                            begin
                                op_pop     = 1'b0;
                                err_next   = 1'b1;
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    emit_res.code = sbqc_pkg::EV_UNCLOSED_BRACE;
                    emit_res.line = ram_rdata;
                    emit_res.last = 1'b0;
                    if ((RW'(idx_reg) + 1'b1) < recorded)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_res.code  = done_code;
                    emit_res.unrec = (depth_ext > SD);
                    op_pop         = 1'b1;
                    round_next     = 1'b0;
                    square_next    = 1'b0;
                    squote_next    = 1'b0;
                    dquote_next    = 1'b0;
                    err_next       = 1'b0;
                    depth_next     = '0;
                    line_next      = sbqc_pkg::LINE_W'(1);
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // control and balance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            round_reg     <= 1'b0;
            square_reg    <= 1'b0;
            squote_reg    <= 1'b0;
            dquote_reg    <= 1'b0;
            err_reg       <= 1'b0;
            depth_reg     <= '0;
            line_reg      <= sbqc_pkg::LINE_W'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            square_reg <= square_next;
            squote_reg <= squote_next;
            dquote_reg <= dquote_next;
            err_reg    <= err_next;
            depth_reg  <= depth_next;
            line_reg   <= line_next;
            idx_reg    <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// File: src/source_bracket_quote_checker.sv
// Bracket and quote balance checker, top level.
// Depends on sbqc_pkg, sbqc_front, sbqc_op_queue and sbqc_back.
//
// Input channel: func and text_byte, transfer when push is high and full is
// low. func 0 carries one source byte, func 1 marks end of text.
// Result channel: event_code, line_number, unrecorded_braces, last_of_run
// are valid while empty is low; a transfer happens when pop is high and
// empty is low. last_of_run marks the final result of one input item.
// The front end classifies bytes and drops those without meaning; a
// four-entry operation queue decouples it from the back end.
// Throughput: one text byte per cycle while the result side keeps up and
// no end of text is being flushed; a newline with several open items gives
// one result per cycle. An operation passes the queue, and its result the
// result register, before it is on the ports. End of text with no open
// brace gives the final status at once; else the back end moves from run
// to a read state, walks the brace line memory via its single registered
// read port, a read and emit state per recorded brace, then final status.
// When the receiver stalls, the back end holds, the queue fills and full
// rises. Reset clears all flags, the brace count, the queue and the result
// valid flag and sets the line count to one; the brace line memory needs no
// clearing, since only entries below the brace count are read.
module source_bracket_quote_checker #(
    parameter int STACK_DEPTH = sbqc_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        func,
    input  logic [sbqc_pkg::BYTE_W-1:0] text_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [sbqc_pkg::CODE_W-1:0] event_code,
    output logic [sbqc_pkg::LINE_W-1:0] line_number,
    output logic                        unrecorded_braces,
    output logic                        last_of_run
);

    logic              enq;
    sbqc_pkg::op_t     enq_op;
    logic              op_valid;
    sbqc_pkg::op_t     head_op;
    logic              op_pop;
    logic              res_valid;
    sbqc_pkg::result_t res;
    logic              res_take;

    // classify incoming bytes
    sbqc_front u_front (
        .push      (push),
        .full      (full),
        .func      (func),
        .text_byte (text_byte),
        .enq       (enq),
        .op        (enq_op)
    );

    // decoupling queue
    sbqc_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_op  (enq_op),
        .full    (full),
        .deq     (op_pop),
        .valid   (op_valid),
        .head_op (head_op)
    );

    // execution and result register
    sbqc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (head_op),
        .op_pop    (op_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // result transfer
    assign res_take          = pop && res_valid;
    assign empty             = !res_valid;
    assign event_code        = res.code;
    assign line_number       = res.line;
    assign unrecorded_braces = res.unrec;
    assign last_of_run       = res.last;

endmodule
